>>> src/tea_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tea_pkg
// Shared types, constants and round-sum helper for the TEA cipher pipeline.
// ----------------------------------------------------------------------------
package tea_pkg;

  localparam int unsigned NumRounds = 32;
  localparam int unsigned NumStages = 2 * NumRounds;
  localparam int unsigned NumKeys   = 4;
  localparam int unsigned WordW     = 32;
  localparam int unsigned KeyIdxW   = $clog2(NumKeys);

  localparam logic [WordW-1:0] TeaDelta = 32'h9e3779b9;

  typedef enum logic {
    KIND_ENCRYPT = 1'b0,
    KIND_DECRYPT = 1'b1
  } kind_e;

  typedef enum logic [KeyIdxW-1:0] {
    KEY_WORD0 = 2'd0,
    KEY_WORD1 = 2'd1,
    KEY_WORD2 = 2'd2,
    KEY_WORD3 = 2'd3
  } key_idx_e;

  typedef logic [NumKeys-1:0][WordW-1:0] key_t;

  typedef struct packed {
    logic             kind;
    logic [WordW-1:0] word_first;
    logic [WordW-1:0] word_second;
  } in_data_t;

  typedef struct packed {
    logic [WordW-1:0] out_first;
    logic [WordW-1:0] out_second;
  } out_data_t;

  // Running sum seen by a half-round stage, modulo 2^32.
  function automatic logic [WordW-1:0] stage_sum(input int unsigned stage, input logic kind);
    int unsigned      rnd;
    logic [WordW-1:0] cnt;
    rnd = stage / 2;
    if (kind == KIND_DECRYPT) begin
      cnt = WordW'(NumRounds - rnd);
    end else begin
      cnt = WordW'(rnd + 1);
    end
    return WordW'(TeaDelta * cnt);
  endfunction

endpackage

>>> src/tea_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tea_stage
// One registered TEA half-round with valid/ready flow control.
// ----------------------------------------------------------------------------
module tea_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 odd_i,
  input  logic [31:0]          enc_sum_i,
  input  logic [31:0]          dec_sum_i,
  input  tea_pkg::key_t        key_i,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  tea_pkg::in_data_t    data_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output tea_pkg::in_data_t    data_o
);

  logic              valid_q;
  tea_pkg::in_data_t data_q, data_d;
  logic              upd_first;
  logic              decrypt;
  logic [31:0]       src, sum, ka, kb, mix;

  assign decrypt   = (data_i.kind == tea_pkg::KIND_DECRYPT);
  assign upd_first = ~(data_i.kind ^ odd_i);
  assign sum       = decrypt ? dec_sum_i : enc_sum_i;

  always_comb begin
    if (upd_first) begin
      src = data_i.word_second;
      ka  = key_i[tea_pkg::KEY_WORD0];
      kb  = key_i[tea_pkg::KEY_WORD1];
    end else begin
      src = data_i.word_first;
      ka  = key_i[tea_pkg::KEY_WORD2];
      kb  = key_i[tea_pkg::KEY_WORD3];
    end
    mix = ((src << 4) + ka) ^ (src + sum) ^ ((src >> 5) + kb);
    data_d = data_i;
    if (upd_first) begin
      data_d.word_first = decrypt ? data_i.word_first - mix : data_i.word_first + mix;
    end else begin
      data_d.word_second = decrypt ? data_i.word_second - mix : data_i.word_second + mix;
    end
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> src/tea_block_cipher_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tea_block_cipher_top
// TEA encrypt/decrypt pipeline, one half-round per register stage.
// ----------------------------------------------------------------------------
// Each block passes all 2*NumRounds (64) half-round stages, each holding one block.
// Throughput: one block per cycle while the output is not stalled.
// A stalled output backs up stage by stage; empty stages still take new blocks.
// Reset clears all stage valid bits and the four key words to zero.
module tea_block_cipher_top (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [tea_pkg::KeyIdxW-1:0] cfg_index_i,
  input  logic [31:0]                 cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  tea_pkg::in_data_t           in_data_i,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output tea_pkg::out_data_t          out_data_o
);

  localparam int unsigned NS = tea_pkg::NumStages;

  tea_pkg::key_t     key_q;
  logic              st_valid [NS+1];
  logic              st_ready [NS+1];
  tea_pkg::in_data_t st_data  [NS+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_q <= '0;
    end else if (cfg_we_i) begin
      key_q[cfg_index_i] <= cfg_wdata_i;
    end
  end

  assign st_valid[0] = in_valid_i;
  assign st_data[0]  = in_data_i;
  assign in_ready_o  = st_ready[0];

  for (genvar s = 0; s < NS; s++) begin : g_stage
    tea_stage u_stage (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .odd_i     (1'(s % 2)),
      .enc_sum_i (tea_pkg::stage_sum(s, tea_pkg::KIND_ENCRYPT)),
      .dec_sum_i (tea_pkg::stage_sum(s, tea_pkg::KIND_DECRYPT)),
      .key_i     (key_q),
      .valid_i   (st_valid[s]),
      .ready_o   (st_ready[s]),
      .data_i    (st_data[s]),
      .valid_o   (st_valid[s+1]),
      .ready_i   (st_ready[s+1]),
      .data_o    (st_data[s+1])
    );
  end

  assign st_ready[NS]          = out_ready_i;
  assign out_valid_o           = st_valid[NS];
  assign out_data_o.out_first  = st_data[NS].word_first;
  assign out_data_o.out_second = st_data[NS].word_second;

  // Input blocked only when every stage is full and the output is stalled (first and last stage checked).
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (st_valid[1] && st_valid[NS] && !out_ready_i))
    else $error("input stalled with a bubble in the pipeline");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_ready_i |-> in_ready_o)
    else $error("ready chain broken while output drains");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> st_valid[1])
    else $error("accepted transfer lost at first stage");

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the TEA block cipher pipeline.
// Blocks are encrypted and decrypted under reset, extreme and random keys.
// The channels run with no idling, with sender gaps and receiver stalls, and
// with both. A scoreboard class predicts every transformed block and checks
// each output transfer in order against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;

  localparam int unsigned IdleLimit = 2000;

  class tea_scoreboard;
    tea_pkg::key_t      key;
    tea_pkg::out_data_t expected_q[$];
    int unsigned        n_err;
    int unsigned        n_checked;
    int unsigned        n_enc;
    int unsigned        n_dec;

    function new();
      key       = '0;
      n_err     = 0;
      n_checked = 0;
      n_enc     = 0;
      n_dec     = 0;
    endfunction

    function void set_key(logic [tea_pkg::KeyIdxW-1:0] idx, logic [tea_pkg::WordW-1:0] val);
      key[idx] = val;
    endfunction

    function logic [tea_pkg::WordW-1:0] mix(logic [tea_pkg::WordW-1:0] v,
                                            logic [tea_pkg::WordW-1:0] sum,
                                            logic [tea_pkg::WordW-1:0] ka,
                                            logic [tea_pkg::WordW-1:0] kb);
      logic [tea_pkg::WordW-1:0] a;
      logic [tea_pkg::WordW-1:0] b;
      logic [tea_pkg::WordW-1:0] c;
      a = (v << 4) + ka;
      b = v + sum;
      c = (v >> 5) + kb;
      return a ^ b ^ c;
    endfunction

    function tea_pkg::out_data_t tea_cipher(tea_pkg::in_data_t blk);
      logic [tea_pkg::WordW-1:0] v0;
      logic [tea_pkg::WordW-1:0] v1;
      logic [tea_pkg::WordW-1:0] sum;
      tea_pkg::out_data_t        res;
      v0 = blk.word_first;
      v1 = blk.word_second;
      if (blk.kind == tea_pkg::KIND_DECRYPT) begin
        sum = tea_pkg::WordW'(tea_pkg::TeaDelta * tea_pkg::NumRounds);
        for (int r = 0; r < tea_pkg::NumRounds; r++) begin
          v1  = v1 - mix(v0, sum, key[tea_pkg::KEY_WORD2], key[tea_pkg::KEY_WORD3]);
          v0  = v0 - mix(v1, sum, key[tea_pkg::KEY_WORD0], key[tea_pkg::KEY_WORD1]);
          sum = sum - tea_pkg::TeaDelta;
        end
      end else begin
        sum = '0;
        for (int r = 0; r < tea_pkg::NumRounds; r++) begin
          sum = sum + tea_pkg::TeaDelta;
          v0  = v0 + mix(v1, sum, key[tea_pkg::KEY_WORD0], key[tea_pkg::KEY_WORD1]);
          v1  = v1 + mix(v0, sum, key[tea_pkg::KEY_WORD2], key[tea_pkg::KEY_WORD3]);
        end
      end
      res.out_first  = v0;
      res.out_second = v1;
      return res;
    endfunction

    function void note_block(tea_pkg::in_data_t blk);
      if (blk.kind == tea_pkg::KIND_DECRYPT) begin
        n_dec++;
      end else begin
        n_enc++;
      end
      expected_q.push_back(tea_cipher(blk));
    endfunction

    function void check_result(tea_pkg::out_data_t got);
      tea_pkg::out_data_t exp_blk;
      if (expected_q.size() == 0) begin
        $error("unexpected output transfer: out_first %h out_second %h",
               got.out_first, got.out_second);
        n_err++;
        return;
      end
      exp_blk = expected_q.pop_front();
      n_checked++;
      if (got.out_first !== exp_blk.out_first) begin
        $error("out_first mismatch: expected %h, got %h", exp_blk.out_first, got.out_first);
        n_err++;
      end
      if (got.out_second !== exp_blk.out_second) begin
        $error("out_second mismatch: expected %h, got %h",
               exp_blk.out_second, got.out_second);
        n_err++;
      end
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_we_i;
  logic [tea_pkg::KeyIdxW-1:0]  cfg_index_i;
  logic [31:0]                  cfg_wdata_i;
  logic                         in_valid_i;
  logic                         in_ready_o;
  tea_pkg::in_data_t            in_data_i;
  logic                         out_valid_o;
  logic                         out_ready_i;
  tea_pkg::out_data_t           out_data_o;

  tea_scoreboard sb = new();
  int unsigned   idle_cycles = 0;
  int unsigned   tx_idle_pct = 0;
  int unsigned   rx_stall_pct = 0;
  int unsigned   n_keysets = 1;

  tea_block_cipher_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= rx_stall_pct);
  end

  // transfer monitor and key shadow
  always @(posedge clk_i) begin
    if (rst_ni && cfg_we_i) begin
      sb.set_key(cfg_index_i, cfg_wdata_i);
    end
    if (rst_ni && in_valid_i && in_ready_o) begin
      sb.note_block(in_data_i);
    end
    if (rst_ni && out_valid_o && out_ready_i) begin
      sb.check_result(out_data_o);
    end
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    while (idle_cycles < IdleLimit) @(posedge clk_i);
    $display("TB_ERROR");
    $finish;
  end

  task automatic send_block(input tea_pkg::in_data_t blk);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= blk;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic wait_for_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sb.pending() != 0);
  endtask

  task automatic put_key(input tea_pkg::key_idx_e idx, input logic [31:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
  endtask

  task automatic load_key(input logic [31:0] k0, input logic [31:0] k1,
                          input logic [31:0] k2, input logic [31:0] k3);
    put_key(tea_pkg::KEY_WORD0, k0);
    put_key(tea_pkg::KEY_WORD1, k1);
    put_key(tea_pkg::KEY_WORD2, k2);
    put_key(tea_pkg::KEY_WORD3, k3);
    cfg_we_i <= 1'b0;
    n_keysets++;
  endtask

  function automatic logic [31:0] pick_word();
    case ($urandom_range(7))
      0:       return 32'h0000_0000;
      1:       return 32'hffff_ffff;
      default: return $urandom();
    endcase
  endfunction

  function automatic tea_pkg::in_data_t make_block(input logic kind, input logic [31:0] w0,
                                                   input logic [31:0] w1);
    tea_pkg::in_data_t blk;
    blk.kind        = kind;
    blk.word_first  = w0;
    blk.word_second = w1;
    return blk;
  endfunction

  initial begin
    tea_pkg::in_data_t  blk;
    tea_pkg::in_data_t  prev;
    tea_pkg::out_data_t ct;
    logic [31:0]        edge_words[5][2];

    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_index_i = tea_pkg::KEY_WORD0;
    cfg_wdata_i = '0;
    in_valid_i  = 1'b0;
    in_data_i   = '0;
    out_ready_i = 1'b0;
    edge_words  = '{'{32'h0, 32'h0}, '{32'hffff_ffff, 32'hffff_ffff},
                    '{32'h0, 32'hffff_ffff}, '{32'hffff_ffff, 32'h0},
                    '{32'h0123_4567, 32'h89ab_cdef}};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset key, both directions, extreme and pattern words
    for (int i = 0; i < 5; i++) begin
      send_block(make_block(tea_pkg::KIND_ENCRYPT, edge_words[i][0], edge_words[i][1]));
      send_block(make_block(tea_pkg::KIND_DECRYPT, edge_words[i][0], edge_words[i][1]));
    end
    wait_for_results();

    load_key('1, '1, '1, '1);
    for (int i = 0; i < 2; i++) begin
      send_block(make_block(tea_pkg::KIND_ENCRYPT, edge_words[i][0], edge_words[i][1]));
      send_block(make_block(tea_pkg::KIND_DECRYPT, edge_words[i][0], edge_words[i][1]));
    end
    wait_for_results();

    // mixed key, round trip back to plaintext
    load_key(32'hffff_ffff, 32'h0, 32'ha5a5_a5a5, 32'h5a5a_5a5a);
    blk = make_block(tea_pkg::KIND_ENCRYPT, 32'h0123_4567, 32'h89ab_cdef);
    send_block(blk);
    ct  = sb.tea_cipher(blk);
    send_block(make_block(tea_pkg::KIND_DECRYPT, ct.out_first, ct.out_second));
    send_block(make_block(tea_pkg::KIND_DECRYPT, 32'hdead_beef, 32'h0));
    wait_for_results();

    // random phases: none, sender gaps, receiver stalls, both
    for (int m = 0; m < 4; m++) begin
      tx_idle_pct  = (m == 1) ? 63 : (m == 3) ? 9 : 0;
      rx_stall_pct = (m == 2) ? 63 : (m == 3) ? 9 : 0;
      load_key($urandom(), $urandom(), $urandom(), $urandom());
      prev = make_block(1'($urandom_range(1)), $urandom(), $urandom());
      for (int n = 0; n < 185; n++) begin
        if (n > 0 && $urandom_range(3) == 0) begin
          ct  = sb.tea_cipher(prev);
          blk = make_block(~prev.kind, ct.out_first, ct.out_second);
        end else begin
          blk = make_block(1'($urandom_range(1)), pick_word(), pick_word());
        end
        send_block(blk);
        prev = blk;
        if ($urandom_range(59) == 0) begin
          wait_for_results();
        end
      end
      wait_for_results();
    end

    repeat (tea_pkg::NumStages + 16) @(posedge clk_i);
    $display("Checked %0d results: %0d encrypt and %0d decrypt blocks under %0d keys,",
             sb.n_checked, sb.n_enc, sb.n_dec, n_keysets);
    $display("with free-running, sender-gapped, receiver-stalled and mixed handshakes.");
    if (sb.n_err == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

>>> files.f
src/tea_pkg.sv
src/tea_stage.sv
src/tea_block_cipher_top.sv
tb/sv/tb.sv
